// ===== rtl/core/ille_pkg.sv =====
// ille_pkg: shared types and codes for the indexed linked-list engine.
// No dependencies.
package ille_pkg;

    localparam logic [2:0] ACT_INSERT     = 3'd0;
    localparam logic [2:0] ACT_REMOVE     = 3'd1;
    localparam logic [2:0] ACT_FIND       = 3'd2;
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd3;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd4;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd5;
    localparam logic [2:0] ACT_POP_BACK   = 3'd6;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
        logic [7:0]  position;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  found_position;
        logic [31:0] front_item;
        logic [31:0] back_item;
        logic [8:0]  item_count;
        logic        list_empty;
    } rsp_t;

    // datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_INIT      = 4'd1;  // build free chain, one slot per cycle
    localparam logic [3:0] CMD_LATCH     = 4'd2;  // capture request, start walk at head
    localparam logic [3:0] CMD_STEP      = 4'd3;  // follow one link
    localparam logic [3:0] CMD_RD_CUR    = 4'd4;  // walk onto removed slot, keep prev
    localparam logic [3:0] CMD_ADD_FRONT = 4'd5;
    localparam logic [3:0] CMD_ADD_BACK  = 4'd6;
    localparam logic [3:0] CMD_ADD_MID   = 4'd7;  // after prev (walk slot)
    localparam logic [3:0] CMD_DROP_FRONT= 4'd8;
    localparam logic [3:0] CMD_DROP_MID  = 4'd9;  // after prev
    localparam logic [3:0] CMD_DROP_BACK = 4'd10; // prev is walk slot
    localparam logic [3:0] CMD_FIX_HEAD  = 4'd11; // second half of multi-write ops
    localparam logic [3:0] CMD_RD_ENDS   = 4'd12;
    localparam logic [3:0] CMD_RD_BACK   = 4'd13;
    localparam logic [3:0] CMD_REPORT    = 4'd14;
    localparam logic [3:0] CMD_GIVE      = 4'd15; // return walk slot to free list

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
        logic       found_hit;
    } ctl_t;

endpackage

// ===== rtl/core/ille_datapath.sv =====
// ille_datapath: slot memories, list pointers, walk register, result register.
// Depends on ille_pkg.
module ille_datapath #(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ille_pkg::req_t req,
    input  ille_pkg::ctl_t ctl,
    output ille_pkg::rsp_t rsp,
    output logic          init_done,
    output logic          is_full,
    output logic [8:0]    count,
    output logic [8:0]    pos_q,
    output logic [8:0]    walk_idx,
    output logic          item_match,
    output logic [2:0]    action_q
);
    import ille_pkg::*;

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [ITEM_WIDTH-1:0] item_mem [CAPACITY];
    logic [SW-1:0]         link_mem [CAPACITY];

    logic [SW-1:0] head_reg, tail_reg, free_reg, walk_reg, init_reg;
    logic [CW-1:0] cnt_reg;
    logic [8:0]    idx_reg;
    logic [ITEM_WIDTH-1:0] val_reg;
    logic [8:0]    pos_reg;
    logic [2:0]    act_reg;
    logic          init_done_reg;
    logic [SW-1:0] link_rd_reg;   // link_mem[walk]
    logic [SW-1:0] flink_rd_reg;  // link_mem[free]
    logic [ITEM_WIDTH-1:0] item_rd_reg;
    logic [ITEM_WIDTH-1:0] front_reg, back_reg;
    rsp_t          rsp_reg;
    logic [SW-1:0] new_reg;

    logic [31:0] val_ext;
    assign val_ext = 32'(val_reg);

    assign init_done = init_done_reg;
    assign is_full   = (cnt_reg == CW'(CAPACITY));
    assign count     = 9'(cnt_reg);
    assign pos_q     = pos_reg;
    assign walk_idx  = idx_reg;
    assign item_match = (item_rd_reg == val_reg);
    assign action_q  = act_reg;
    assign rsp       = rsp_reg;

    // memory reads, registered
    always_ff @(posedge clk)
    begin
        link_rd_reg  <= link_mem[walk_reg];
        flink_rd_reg <= link_mem[free_reg];
        item_rd_reg  <= item_mem[walk_reg];
    end

    // memory writes: one link write and one item write per cycle
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            CMD_INIT:
                link_mem[init_reg] <= (32'(init_reg) == CAPACITY - 1) ? '0 : init_reg + 1'b1;
            CMD_ADD_FRONT:
            begin
                item_mem[free_reg] <= val_reg;
                link_mem[free_reg] <= (cnt_reg == '0) ? '0 : head_reg;
            end
            CMD_ADD_BACK:
            begin
                item_mem[free_reg] <= val_reg;
                link_mem[free_reg] <= '0;
            end
            CMD_ADD_MID:
            begin
                item_mem[free_reg] <= val_reg;
                link_mem[free_reg] <= link_rd_reg;
            end
            CMD_FIX_HEAD:
            begin
                // second write: back link of old tail or prev link
                if (act_reg == ACT_INSERT && pos_reg < 9'(cnt_reg) - 9'd1 && pos_reg != 9'd0)
                    link_mem[walk_reg] <= new_reg;
                else if (cnt_reg > CW'(1))
                    link_mem[tail_reg] <= new_reg;
            end
            CMD_DROP_FRONT:
                link_mem[head_reg] <= free_reg;
            CMD_DROP_MID:
                // new_reg holds prev, link_rd_reg the successor of the removed slot
                link_mem[new_reg] <= (pos_reg == 9'(cnt_reg) - 9'd1) ? '0 : link_rd_reg;
            CMD_DROP_BACK:
                link_mem[walk_reg] <= '0;
            CMD_GIVE:
                link_mem[walk_reg] <= free_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0; tail_reg <= '0; free_reg <= '0; walk_reg <= '0;
            init_reg <= '0; cnt_reg <= '0; idx_reg <= '0; init_done_reg <= 1'b0;
        end
        else
        begin
            case (ctl.op)
                CMD_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (32'(init_reg) == CAPACITY - 1) init_done_reg <= 1'b1;
                end
                CMD_LATCH:
                begin
                    walk_reg <= head_reg;
                    idx_reg  <= '0;
                end
                CMD_STEP:
                begin
                    walk_reg <= link_rd_reg;
                    idx_reg  <= idx_reg + 9'd1;
                end
                CMD_ADD_FRONT:
                begin
                    new_reg  <= free_reg;
                    head_reg <= free_reg;
                    if (cnt_reg == '0) tail_reg <= free_reg;
                    free_reg <= flink_rd_reg;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                CMD_ADD_BACK, CMD_ADD_MID:
                begin
                    new_reg  <= free_reg;
                    if (cnt_reg == '0) head_reg <= free_reg;
                    free_reg <= flink_rd_reg;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                CMD_FIX_HEAD:
                begin
                    if (ctl.status == ST_FULL) tail_reg <= new_reg;
                    walk_reg <= head_reg;
                end
                CMD_DROP_FRONT:
                begin
                    free_reg <= head_reg;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        head_reg <= '0; tail_reg <= '0;
                    end
                    else
                        head_reg <= link_rd_reg;
                end
                CMD_RD_CUR:
                begin
                    // link_rd_reg holds removed slot t; park prev in new_reg
                    new_reg  <= walk_reg;
                    walk_reg <= link_rd_reg;
                end
                CMD_DROP_MID:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (pos_reg == 9'(cnt_reg) - 9'd1) tail_reg <= new_reg;
                end
                CMD_DROP_BACK:
                begin
                    walk_reg <= tail_reg;
                    tail_reg <= walk_reg;
                    cnt_reg  <= cnt_reg - 1'b1;
                end
                CMD_GIVE:
                    free_reg <= walk_reg;
                CMD_RD_ENDS:
                    walk_reg <= head_reg;
                CMD_RD_BACK:
                    walk_reg <= tail_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == CMD_LATCH)
        begin
            val_reg <= ITEM_WIDTH'(req.value);
            pos_reg <= {1'b0, req.position};
            act_reg <= req.action;
        end
        if (ctl.op == CMD_RD_BACK) front_reg <= item_rd_reg;
        if (ctl.op == CMD_REPORT)
        begin
            back_reg <= item_rd_reg;
            rsp_reg.status         <= ctl.status;
            rsp_reg.found_position <= (act_reg == ACT_FIND)
                                      ? (ctl.found_hit ? idx_reg : 9'(cnt_reg)) : 9'd0;
            rsp_reg.front_item     <= (cnt_reg == '0) ? 32'd0 : 32'(front_reg);
            rsp_reg.back_item      <= (cnt_reg == '0) ? 32'd0 : 32'(item_rd_reg);
            rsp_reg.item_count     <= 9'(cnt_reg);
            rsp_reg.list_empty     <= (cnt_reg == '0);
        end
    end

    logic unused_ok;
    assign unused_ok = ^{val_ext, back_reg};

endmodule

// ===== rtl/core/ille_control.sv =====
// ille_control: sequencer for the engine; drives commands into ille_datapath.
// Depends on ille_pkg.
module ille_control (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic [2:0]     in_action,
    input  logic           init_done,
    input  logic           is_full,
    input  logic [8:0]     count,
    input  logic [8:0]     pos_q,
    input  logic [8:0]     walk_idx,
    input  logic           item_match,
    input  logic [2:0]     action_q,
    output ille_pkg::ctl_t ctl
);
    import ille_pkg::*;

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_DISPATCH = 4'd2,
                           S_WALK = 4'd3, S_WWAIT = 4'd4, S_FIX = 4'd5,
                           S_ENDS = 4'd6, S_EW1 = 4'd7, S_EW2 = 4'd8,
                           S_EW3 = 4'd9, S_OUT = 4'd10, S_FREE = 4'd11,
                           S_PRE = 4'd12, S_FWAIT = 4'd13, S_GIVE = 4'd14,
                           S_BWAIT = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       hit_reg, hit_next;
    logic       ovalid_reg, ovalid_next;
    logic [8:0] target;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    // walk target: prev for insert/remove, count-2 for pop back, count for find
    always_comb
    begin
        case (action_q)
            ACT_POP_BACK: target = count - 9'd2;
            ACT_FIND:     target = count;
            default:      target = pos_q - 9'd1;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        ovalid_next = ovalid_reg;
        ctl.op      = CMD_NONE;
        ctl.status  = status_reg;
        ctl.found_hit = hit_reg;
        if (ovalid_reg && out_ready) ovalid_next = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ctl.op = CMD_INIT;
                if (init_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op = CMD_LATCH;
                    status_next = ST_DONE;
                    hit_next = 1'b0;
                    state_next = S_PRE;
                end
            end
            S_PRE:
                state_next = S_DISPATCH;  // reads of head/free settle
            S_DISPATCH:
            begin
                state_next = S_ENDS;
                case (action_q)
                    ACT_INSERT:
                        if (is_full) status_next = ST_FULL;
                        else if (pos_q >= count)
                        begin
                            ctl.op = CMD_ADD_BACK; state_next = S_FIX;
                        end
                        else if (pos_q == 9'd0) ctl.op = CMD_ADD_FRONT;
                        else state_next = S_WALK;
                    ACT_PUSH_FRONT:
                        if (is_full) status_next = ST_FULL;
                        else ctl.op = CMD_ADD_FRONT;
                    ACT_PUSH_BACK:
                        if (is_full) status_next = ST_FULL;
                        else
                        begin
                            ctl.op = CMD_ADD_BACK; state_next = S_FIX;
                        end
                    ACT_REMOVE:
                        if (pos_q >= count) status_next = ST_RANGE;
                        else if (pos_q == 9'd0) ctl.op = CMD_DROP_FRONT;
                        else state_next = S_WALK;
                    ACT_POP_FRONT:
                        if (count == 9'd0) status_next = ST_RANGE;
                        else ctl.op = CMD_DROP_FRONT;
                    ACT_POP_BACK:
                        if (count == 9'd0) status_next = ST_RANGE;
                        else if (count == 9'd1) ctl.op = CMD_DROP_FRONT;
                        else state_next = S_WALK;
                    ACT_FIND:
                        state_next = S_WALK;
                    default:
                        status_next = ST_RANGE;
                endcase
            end
            S_WALK:
            begin
                // registered reads for walk slot are valid here
                if (action_q == ACT_FIND && walk_idx < count && item_match)
                begin
                    hit_next = 1'b1; state_next = S_ENDS;
                end
                else if (walk_idx == target) begin
                    case (action_q)
                        ACT_INSERT:
                        begin
                            ctl.op = CMD_ADD_MID; state_next = S_FIX;
                        end
                        ACT_POP_BACK:
                        begin
                            ctl.op = CMD_DROP_BACK; state_next = S_GIVE;
                        end
                        ACT_REMOVE: state_next = S_FREE;
                        default: state_next = S_ENDS;
                    endcase
                end
                else
                begin
                    ctl.op = CMD_STEP; state_next = S_WWAIT;
                end
            end
            S_WWAIT: state_next = S_WALK;
            S_FIX:
            begin
                // second link write of an insert; full code marks tail update
                ctl.op = CMD_FIX_HEAD;
                ctl.status = (action_q != ACT_INSERT || pos_q >= count - 9'd1)
                             ? ST_FULL : ST_DONE;
                state_next = S_ENDS;
            end
            S_FREE:
            begin
                // step onto removed slot t, keep prev; then wait for link_mem[t]
                ctl.op = CMD_RD_CUR; state_next = S_FWAIT;
            end
            S_FWAIT: state_next = S_EW3;
            S_EW3:
            begin
                ctl.op = CMD_DROP_MID; state_next = S_GIVE;
            end
            S_GIVE:
            begin
                // removed slot goes back on the free list
                ctl.op = CMD_GIVE; state_next = S_ENDS;
            end
            S_ENDS:
            begin
                ctl.op = CMD_RD_ENDS; state_next = S_EW1;
            end
            S_EW1: state_next = S_EW2;
            S_EW2:
            begin
                ctl.op = CMD_RD_BACK; state_next = S_BWAIT;
            end
            S_BWAIT: state_next = S_OUT;  // tail item read settles
            S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
        if (state_reg == S_OUT && (!ovalid_reg || out_ready))
        begin
            ctl.op = CMD_REPORT; ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT; status_reg <= ST_DONE;
            hit_reg <= 1'b0; ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; status_reg <= status_next;
            hit_reg <= hit_next; ovalid_reg <= ovalid_next;
        end
    end

    logic unused_ok;
    assign unused_ok = ^in_action;

endmodule

// ===== rtl/core/indexed_linked_list_engine.sv =====
// indexed_linked_list_engine: top level, ordered list in a linked slot store.
// Depends on ille_pkg, ille_control, ille_datapath.
//
//  channel | dir | payload | transfer when
//  in      | in  | req_t   | in_valid && in_ready
//  out     | out | rsp_t   | out_valid && out_ready
//
// One item at a time. Push front, pop front, remove at position 0, append and
// every error need no walk. Insert, remove, find and pop back walk the list
// one link at a time, waiting on the registered read of the link memory
// between links; a find that misses walks the whole list.
// Reset: a pass over every slot chains the free list; no item is taken then.
// Stalls: the result register holds until taken; one item is in flight.
module indexed_linked_list_engine #(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ille_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ille_pkg::rsp_t out_data
);
    import ille_pkg::*;

    ctl_t       ctl;
    logic       init_done, is_full, item_match;
    logic [8:0] count, pos_q, walk_idx;
    logic [2:0] action_q;

    ille_control u_ctl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .in_action(in_data.action),
        .init_done(init_done), .is_full(is_full), .count(count),
        .pos_q(pos_q), .walk_idx(walk_idx), .item_match(item_match),
        .action_q(action_q), .ctl(ctl)
    );

    ille_datapath #(.CAPACITY(CAPACITY), .ITEM_WIDTH(ITEM_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .ctl(ctl), .rsp(out_data),
        .init_done(init_done), .is_full(is_full), .count(count),
        .pos_q(pos_q), .walk_idx(walk_idx), .item_match(item_match),
        .action_q(action_q)
    );

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count) <= CAPACITY) else $error("count above capacity");

    // empty flag agrees with count on every result
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.list_empty == (out_data.item_count == 9'd0)))
        else $error("empty flag mismatch");

    // a waiting result stays valid and steady until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while waiting");

endmodule

// ===== verif/tb_indexed_linked_list_engine.sv =====
// Testbench for indexed_linked_list_engine: directed and random list actions,
// checked against an in-bench list model. Depends on ille_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_indexed_linked_list_engine;
    import ille_pkg::*;

    localparam int CAP        = 256;
    localparam int STALL_MAX  = 20000;  // cycles without any transfer

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    indexed_linked_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // List contents in order, front at index 0; the slot layout is not
    // visible at the ports so an ordered queue is enough to predict results.
    logic [31:0] list_q[$];
    rsp_t        rsp_pending[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_cnt;
    int stall_cnt;
    bit timed_out;

    // Apply one request to the list and return the response it must produce.
    function automatic rsp_t list_apply(req_t r);
        rsp_t o;
        int   n;
        bit   full;
        n = list_q.size();
        full = (n >= CAP);
        o = '0;
        o.status = ST_DONE;
        case (r.action)
            ACT_INSERT:
                if (full) o.status = ST_FULL;
                else if (r.position >= n) list_q.insert(n, r.value);
                else list_q.insert(r.position, r.value);
            ACT_REMOVE:
                if (r.position >= n) o.status = ST_RANGE;
                else list_q.delete(r.position);
            ACT_FIND:
            begin
                o.found_position = 9'(n);
                for (int i = 0; i < n; i++)
                begin
                    if (list_q[i] == r.value)
                    begin
                        o.found_position = 9'(i);
                        break;
                    end
                end
            end
            ACT_PUSH_FRONT:
                if (full) o.status = ST_FULL;
                else list_q.insert(0, r.value);
            ACT_PUSH_BACK:
                if (full) o.status = ST_FULL;
                else list_q.insert(n, r.value);
            ACT_POP_FRONT:
                if (n == 0) o.status = ST_RANGE;
                else list_q.delete(0);
            ACT_POP_BACK:
                if (n == 0) o.status = ST_RANGE;
                else list_q.delete(n - 1);
            default:
                o.status = ST_RANGE;
        endcase
        n = list_q.size();
        o.item_count = 9'(n);
        o.list_empty = (n == 0);
        o.front_item = n ? list_q[0] : 32'd0;
        o.back_item  = n ? list_q[n-1] : 32'd0;
        return o;
    endfunction

    // Send one request: random pre-gap, then hold valid until the transfer.
    task automatic send_req(input logic [2:0] act, input logic [31:0] val,
                            input logic [7:0] pos);
        req_t r;
        rsp_t e;
        r.action = act;
        r.value = val;
        r.position = pos;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        e = list_apply(r);
        rsp_pending = {rsp_pending, e};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rsp_pending.size() != 0)
            @(posedge clk);
    endtask

    // About a third of the values come from the list so finds hit; the rest are mostly small.
    function automatic logic [31:0] pick_value();
        if (list_q.size() != 0 && $urandom_range(2) == 0)
            return list_q[$urandom_range(list_q.size() - 1)];
        return $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(15));
    endfunction

    function automatic logic [7:0] pick_pos();
        int n;
        n = list_q.size();
        if ($urandom_range(9) == 0)
            return 8'($urandom());
        return 8'($urandom_range(n));
    endfunction

    // Result checker with receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rsp_pending.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result %p", out_data);
                end
                else
                begin
                    rsp_t e;
                    e = rsp_pending[0];
                    rsp_pending.delete(0);
                    if (out_data.status !== e.status
                        || out_data.found_position !== e.found_position
                        || out_data.front_item !== e.front_item
                        || out_data.back_item !== e.back_item
                        || out_data.item_count !== e.item_count
                        || out_data.list_empty !== e.list_empty)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: expected %p actual %p", e, out_data);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_MAX && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[indexed_linked_list_engine] ERROR");
            $finish;
        end
    end

    // Every action, each special case, field extremes.
    task automatic test_directed();
        send_req(ACT_POP_FRONT, 32'd0, 8'd0);       // empty pop
        send_req(ACT_POP_BACK, 32'd0, 8'd0);
        send_req(ACT_REMOVE, 32'd0, 8'd0);          // remove past end
        send_req(ACT_FIND, 32'hFFFF_FFFF, 8'd0);    // find on empty list
        send_req(3'd7, 32'hFFFF_FFFF, 8'hFF);       // unused code
        send_req(ACT_PUSH_BACK, 32'hFFFF_FFFF, 8'd0);
        send_req(ACT_PUSH_FRONT, 32'd0, 8'd0);
        send_req(ACT_INSERT, 32'h5555_AAAA, 8'd1);
        send_req(ACT_INSERT, 32'hAAAA_5555, 8'hFF); // append
        send_req(ACT_INSERT, 32'h1234_5678, 8'd0);
        send_req(ACT_FIND, 32'hAAAA_5555, 8'd0);
        send_req(ACT_FIND, 32'hDEAD_BEEF, 8'd0);
        send_req(ACT_REMOVE, 32'd0, 8'd2);
        send_req(ACT_REMOVE, 32'd0, 8'd3);          // last position
        send_req(ACT_REMOVE, 32'd0, 8'hFF);
        send_req(ACT_POP_BACK, 32'd0, 8'd0);
        send_req(ACT_POP_FRONT, 32'd0, 8'd0);
        send_req(ACT_REMOVE, 32'd0, 8'd0);
        wait_drained();                              // sender holds off
    endtask

    // Fill the store to capacity, hit the full status, then drain.
    task automatic test_full_store();
        while (list_q.size() < CAP)
            send_req($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                     $urandom(), 8'd0);
        send_req(ACT_INSERT, 32'd1, 8'd5);
        send_req(ACT_PUSH_FRONT, 32'd1, 8'd0);
        send_req(ACT_PUSH_BACK, 32'd1, 8'd0);
        send_req(ACT_FIND, 32'hFFFF_FFFF, 8'd0);
        send_req(ACT_REMOVE, 32'd0, 8'd255);
        send_req(ACT_INSERT, list_q[3], 8'd255);
        send_req(ACT_POP_BACK, 32'd0, 8'd0);
        while (list_q.size() > 0)
            send_req(ACT_POP_FRONT, 32'd0, 8'd0);
    endtask

    // Random mix biased to keep the list short so walks stay cheap.
    task automatic test_random(input int count);
        logic [2:0] act;
        for (int i = 0; i < count; i++)
        begin
            if (list_q.size() > 24 && $urandom_range(1))
                act = $urandom_range(1) ? ACT_REMOVE : ACT_POP_BACK;
            else
                act = 3'($urandom_range(7));
            send_req(act, pick_value(), pick_pos());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatch_cnt = 0;
        stall_cnt = 0;
        timed_out = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 78;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(80);
        send_idle_pct = 78;
        recv_idle_pct = 20;
        test_random(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_store();
        test_random(160);

        wait_drained();
        repeat (600) @(posedge clk);
        if (mismatch_cnt == 0 && rsp_pending.size() == 0)
            $display("[indexed_linked_list_engine] OK");
        else
            $display("[indexed_linked_list_engine] ERROR");
        $finish;
    end

endmodule
